// ----- rtl/tdfa_pkg.sv -----
// ----------------------------------------------------------------------------
// tdfa_pkg
// Shared types and constants for the table-driven DFA stepper.
// ----------------------------------------------------------------------------
package tdfa_pkg;

    localparam int STATES    = 64;
    localparam int SYMBOLS   = 16;
    localparam int STATE_W   = $clog2(STATES);
    localparam int SYM_W     = $clog2(SYMBOLS);
    localparam int ADDR_W    = STATE_W + SYM_W;
    localparam int TBL_DEPTH = STATES * SYMBOLS;

    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 64;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;

    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STEP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT = 8'd1;

    // one transition table entry
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] target;
    } entry_t;

    // table write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } tbl_wr_t;

    // step or restart item entering the walk stage
    typedef struct packed {
        logic               valid;
        logic               restart;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] start;
    } walk_req_t;

    // result item
    typedef struct packed {
        logic [STATE_W-1:0] prev_state;
        logic [SYM_W-1:0]   step_symbol;
        logic [STATE_W-1:0] new_state;
        logic               accepted;
        logic               trapped;
        logic               was_restart;
    } result_t;

endpackage

// ----- rtl/tdfa_table.sv -----
// ----------------------------------------------------------------------------
// tdfa_table
// Transition table memory: one write port, one registered read port, and a
// clearing sweep after reset that marks every entry undefined.
// ----------------------------------------------------------------------------
module tdfa_table (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tdfa_pkg::tbl_wr_t       wr,
    input  logic                    rd_en,
    input  logic [tdfa_pkg::ADDR_W-1:0] rd_addr,
    output tdfa_pkg::entry_t        rd_data,
    output logic                    busy
);
    import tdfa_pkg::*;

    entry_t            mem [TBL_DEPTH];
    entry_t            rd_data_reg;
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(TBL_DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

// ----- rtl/tdfa_walk.sv -----
// ----------------------------------------------------------------------------
// tdfa_walk
// Resolves a step or restart against the table read data, keeps the current
// state and trap flag, and holds the result in the output register.
// ----------------------------------------------------------------------------
module tdfa_walk (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tdfa_pkg::walk_req_t          req,
    input  tdfa_pkg::entry_t             rd_data,
    input  logic [tdfa_pkg::CFG_W-1:0]   accept_mask,
    output logic [tdfa_pkg::STATE_W-1:0] cur_state,
    output logic                         ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output tdfa_pkg::result_t            out_data
);
    import tdfa_pkg::*;

    logic               p1_valid_reg;
    logic               p1_restart_reg;
    logic [SYM_W-1:0]   p1_sym_reg;
    logic [STATE_W-1:0] p1_prev_reg;
    logic [STATE_W-1:0] p1_start_reg;
    logic               p1_trap_reg;

    logic [STATE_W-1:0] cur_reg;
    logic               trap_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    result_t            res;
    logic               p1_move;
    logic               trap_fwd;

    always_comb begin
        res = '0;
        if (p1_restart_reg) begin
            res.prev_state  = p1_start_reg;
            res.new_state   = p1_start_reg;
            res.trapped     = 1'b0;
            res.was_restart = 1'b1;
        end else begin
            res.prev_state  = p1_prev_reg;
            res.step_symbol = p1_sym_reg;
            // stay trapped, or trap on an undefined transition
            if (!p1_trap_reg && rd_data.valid) begin
                res.new_state = rd_data.target;
                res.trapped   = 1'b0;
            end else begin
                res.new_state = '0;
                res.trapped   = 1'b1;
            end
        end
        res.accepted = !res.trapped && accept_mask[res.new_state];
    end

    // forward the state of the item in flight to the next table read
    assign cur_state = p1_valid_reg ? res.new_state : cur_reg;
    assign trap_fwd  = p1_valid_reg ? res.trapped   : trap_reg;

    assign p1_move = !out_valid_reg || out_ready;
    assign ready   = !p1_valid_reg || p1_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            trap_reg      <= 1'b0;
        end else begin
            if (p1_valid_reg && p1_move) begin
                out_valid_reg <= 1'b1;
                cur_reg       <= res.new_state;
                trap_reg      <= res.trapped;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (ready) begin
                p1_valid_reg <= req.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg && p1_move) begin
            out_reg <= res;
        end
        if (ready && req.valid) begin
            p1_restart_reg <= req.restart;
            p1_sym_reg     <= req.sym;
            p1_start_reg   <= req.start;
            p1_prev_reg    <= cur_state;
            p1_trap_reg    <= trap_fwd;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/table_driven_dfa_stepper.sv -----
// ----------------------------------------------------------------------------
// table_driven_dfa_stepper
// A step or restart item passes p1, then the output register, to m_tvalid.
// Throughput: one item per cycle while m_tready is high; the table read at
// {state, symbol} of one step feeds the address of the next step through a
// forwarding mux. Reset: control and config registers clear, then a sweep marks
// every table entry undefined with s_tready low; config writes still land.
// ----------------------------------------------------------------------------
module table_driven_dfa_stepper (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tdfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tdfa_pkg::CFG_W-1:0]     cfg_data,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tdfa_pkg::S_DATA_W-1:0]  s_tdata,  // from_state, symbol, target_state
    input  logic [tdfa_pkg::REQ_W-1:0]     s_tuser,  // req_type
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tdfa_pkg::M_DATA_W-1:0]  m_tdata,  // prev_state, step_symbol,
                                                     // new_state, accepted, trapped
    output logic                           m_tuser   // was_restart
);
    import tdfa_pkg::*;

    logic [STATE_W-1:0] start_state_reg;
    logic [CFG_W-1:0]   accept_mask_reg;

    logic [STATE_W-1:0] in_from;
    logic [SYM_W-1:0]   in_sym;
    logic [STATE_W-1:0] in_target;
    logic               in_accept;

    tbl_wr_t            wr;
    walk_req_t          wreq;
    entry_t             rd_data;
    logic               tbl_busy;
    logic               walk_ready;
    logic [STATE_W-1:0] cur_state;
    logic               rd_en;
    result_t            res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_state_reg <= '0;
            accept_mask_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_START:  start_state_reg <= cfg_data[STATE_W-1:0];
                CFG_ACCEPT: accept_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_from   = s_tdata[STATE_W-1:0];
    assign in_sym    = s_tdata[STATE_W +: SYM_W];
    assign in_target = s_tdata[STATE_W+SYM_W +: STATE_W];

    assign s_tready  = !tbl_busy && walk_ready;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        wr.en          = in_accept && (s_tuser == REQ_LOAD);
        wr.addr        = {in_from, in_sym};
        wr.data.valid  = 1'b1;
        wr.data.target = in_target;
    end

    always_comb begin
        wreq.valid   = in_accept && ((s_tuser == REQ_STEP) || (s_tuser == REQ_RESTART));
        wreq.restart = (s_tuser == REQ_RESTART);
        wreq.sym     = in_sym;
        wreq.start   = start_state_reg;
    end

    assign rd_en = in_accept && (s_tuser == REQ_STEP);

    tdfa_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr ({cur_state, in_sym}),
        .rd_data (rd_data),
        .busy    (tbl_busy)
    );

    tdfa_walk u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (wreq),
        .rd_data     (rd_data),
        .accept_mask (accept_mask_reg),
        .cur_state   (cur_state),
        .ready       (walk_ready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (res)
    );

    assign m_tdata = {6'd0, res.trapped, res.accepted, res.new_state,
                      res.step_symbol, res.prev_state};
    assign m_tuser = res.was_restart;

endmodule
